FILE: design/vnorm_pkg.sv
// Shared constants for the 3D vector normalisation core.
// No dependencies; vector3_normalize_core and vnorm_checker refer to this package by scoped names.
package vnorm_pkg;

	localparam int COMPONENT_WIDTH = 32;
	localparam int FRACTION_BITS   = 16;
	// bit position that the largest rescaled component is aligned to
	localparam int SCALE_TOP       = 23;

endpackage

FILE: design/vector3_normalize_core.sv
// Top level of the 3D vector normalisation core: length and unit vector of a Q16.16 vector.
// Depends on vnorm_pkg and vnorm_root.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+-------------------------------------
//  s_ (in)   | to core   | s_tvalid / s_tready     | s_tdata: comp_x, comp_y, comp_z
//  m_ (out)  | from core | m_tvalid / m_tready     | m_tdata: unit_x/y/z, magnitude;
//            |           |                         | m_tuser: zero_length
//
// One vector enters per clock unless a stall at m_tready holds s_tready low; the root
// pipelines resolve one result bit per stage.
// The whole pipeline advances together whenever the output register is empty or taken;
// a stall at m_tready freezes every stage and holds s_tready low, losing nothing.
// Reset clears only the valid bits; data registers carry no reset.
module vector3_normalize_core #(
	parameter int COMPONENT_WIDTH = vnorm_pkg::COMPONENT_WIDTH,
	parameter int FRACTION_BITS   = vnorm_pkg::FRACTION_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// comp_x, comp_y, comp_z from bit 0 up, zero padded to whole bytes
	input  logic [((3 * COMPONENT_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// unit_x, unit_y, unit_z, magnitude from bit 0 up, zero padded to whole bytes
	output logic [((3 * (FRACTION_BITS + 2) + COMPONENT_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
	// zero_length
	output logic m_tuser
);

	localparam int CW      = COMPONENT_WIDTH;
	localparam int F       = FRACTION_BITS;
	localparam int UW      = F + 2;
	localparam int SW      = vnorm_pkg::SCALE_TOP + 1;
	localparam int TOPW    = $clog2(CW);
	localparam int LEN_NW  = 2 * CW + 2;
	localparam int UNIT_KW = F + 2;
	localparam int UNIT_DW = 2 * SW + 2;
	localparam int UNIT_NW = 2 * SW + 2 * F + 2;

	typedef struct packed {
		logic                 zero;
		logic [2:0]           neg;
		logic [TOPW-1:0]      top;
		logic [2:0][CW-1:0]   mag;
	} len_pay_t;

	typedef struct packed {
		logic                 zero;
		logic [2:0]           neg;
		logic [CW-1:0]        len;
	} unit_pay_t;

	// advance the whole pipeline when the output register is free or being drained
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---------------------------------------------------------------- stage 1: magnitudes
	logic [2:0][CW-1:0] comp;
	logic [2:0][CW-1:0] mag_in;
	logic [2:0]         neg_in;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			comp[i]   = s_tdata[i*CW +: CW];
			neg_in[i] = comp[i][CW-1];
			// the most negative code maps to 2^(CW-1), which still fits unsigned
			mag_in[i] = neg_in[i] ? ~comp[i] + CW'(1) : comp[i];
		end
	end

	logic               valid_s1;
	logic [2:0][CW-1:0] mag_s1;
	logic [2:0]         neg_s1;
	logic               zero_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag_in;
			neg_s1  <= neg_in;
			zero_s1 <= (comp == '0);
		end
	end

	// ---------------------------------------------------------------- stage 2: squares, largest
	logic                   valid_s2;
	logic [2:0][2*CW-1:0]   sq_s2;
	logic [CW-1:0]          big_s2;
	logic [2:0][CW-1:0]     mag_s2;
	logic [2:0]             neg_s2;
	logic                   zero_s2;
	logic [CW-1:0]          big_xy;

	assign big_xy = (mag_s1[1] > mag_s1[0]) ? mag_s1[1] : mag_s1[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= (2 * CW)'(mag_s1[i]) * (2 * CW)'(mag_s1[i]);
			end
			big_s2  <= (mag_s1[2] > big_xy) ? mag_s1[2] : big_xy;
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3: sum, leading one
	logic [TOPW-1:0] top_nx;

	always_comb begin
		top_nx = '0;
		for (int b = 0; b < CW; b++) begin
			if (big_s2[b]) begin
				top_nx = TOPW'(b);
			end
		end
	end

	logic              valid_s3;
	logic [LEN_NW-1:0] sumsq_s3;
	len_pay_t          lpay_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sumsq_s3     <= LEN_NW'(sq_s2[0]) + LEN_NW'(sq_s2[1]) + LEN_NW'(sq_s2[2]);
			lpay_s3.zero <= zero_s2;
			lpay_s3.neg  <= neg_s2;
			lpay_s3.top  <= top_nx;
			lpay_s3.mag  <= mag_s2;
		end
	end

	// ---------------------------------------------------------------- length: integer square root
	logic                 len_valid;
	logic [0:0][CW-1:0]   len_root;
	len_pay_t             lpay_out;

	vnorm_root #(
		.LANES (1),
		.KW    (CW),
		.NW    (LEN_NW),
		.DW    (1),
		.PW    ($bits(len_pay_t))
	) u_len_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.in_num    (sumsq_s3),
		.in_div    (1'b1),
		.in_pay    (lpay_s3),
		.out_valid (len_valid),
		.out_root  (len_root),
		.out_pay   (lpay_out)
	);

	// ---------------------------------------------------------------- stage 4: rescale
	// align the largest magnitude so its top bit sits at SCALE_TOP; right shifts drop low bits
	logic [2:0][SW-1:0] scaled_nx;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (int'(lpay_out.top) > vnorm_pkg::SCALE_TOP) begin
				scaled_nx[i] = SW'(lpay_out.mag[i] >> (int'(lpay_out.top) - vnorm_pkg::SCALE_TOP));
			end else begin
				scaled_nx[i] = SW'(lpay_out.mag[i]) << (vnorm_pkg::SCALE_TOP - int'(lpay_out.top));
			end
		end
	end

	logic               valid_s4;
	logic [2:0][SW-1:0] scaled_s4;
	unit_pay_t          upay_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= len_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scaled_s4    <= scaled_nx;
			upay_s4.zero <= lpay_out.zero;
			upay_s4.neg  <= lpay_out.neg;
			upay_s4.len  <= len_root[0];
		end
	end

	// ---------------------------------------------------------------- stage 5: rescaled squares
	logic                 valid_s5;
	logic [2:0][2*SW-1:0] csq_s5;
	unit_pay_t            upay_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				csq_s5[i] <= (2 * SW)'(scaled_s4[i]) * (2 * SW)'(scaled_s4[i]);
			end
			upay_s5 <= upay_s4;
		end
	end

	// ---------------------------------------------------------------- stage 6: divisor, numerators
	logic                    valid_s6;
	logic [UNIT_DW-1:0]      ssum_s6;
	logic [2:0][UNIT_NW-1:0] num_s6;
	unit_pay_t               upay_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ssum_s6 <= UNIT_DW'(csq_s5[0]) + UNIT_DW'(csq_s5[1]) + UNIT_DW'(csq_s5[2]);
			for (int i = 0; i < 3; i++) begin
				num_s6[i] <= UNIT_NW'(csq_s5[i]) << (2 * F + 2);
			end
			upay_s6 <= upay_s5;
		end
	end

	// ---------------------------------------------------------------- unit: k = floor(c*2^(F+1)/L)
	logic                    unit_valid;
	logic [2:0][UNIT_KW-1:0] unit_root;
	unit_pay_t               upay_out;

	vnorm_root #(
		.LANES (3),
		.KW    (UNIT_KW),
		.NW    (UNIT_NW),
		.DW    (UNIT_DW),
		.PW    ($bits(unit_pay_t))
	) u_unit_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s6),
		.in_num    (num_s6),
		.in_div    (ssum_s6),
		.in_pay    (upay_s6),
		.out_valid (unit_valid),
		.out_root  (unit_root),
		.out_pay   (upay_out)
	);

	// ---------------------------------------------------------------- stage 7: round, sign, output
	// round half up: q = floor((k + 1) / 2), clamped to 1.0
	logic [2:0][UW-1:0] unit_nx;
	logic [2:0][UW:0]   kp;
	logic [2:0][UW-1:0] q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			kp[i] = (UW + 1)'(unit_root[i]) + (UW + 1)'(1);
			q[i]  = kp[i][UW:1];
			if (q[i] > (UW'(1) << F)) begin
				q[i] = UW'(1) << F;
			end
			if (upay_out.zero) begin
				unit_nx[i] = '0;
			end else begin
				unit_nx[i] = upay_out.neg[i] ? ~q[i] + UW'(1) : q[i];
			end
		end
	end

	logic               valid_s7;
	logic [2:0][UW-1:0] unit_s7;
	logic [CW-1:0]      len_s7;
	logic               zero_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= unit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unit_s7 <= unit_nx;
			len_s7  <= upay_out.zero ? '0 : upay_out.len;
			zero_s7 <= upay_out.zero;
		end
	end

	assign m_tvalid = valid_s7;
	assign m_tuser  = zero_s7;

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < 3; i++) begin
			m_tdata[i*UW +: UW] = unit_s7[i];
		end
		m_tdata[3*UW +: CW] = len_s7;
	end

endmodule

FILE: design/vnorm_root.sv
// Pipelined bit-serial root search: per lane, the largest k with k*k*div <= num.
// One result bit per register stage; valid bits and a side payload travel with the data.
// Depends on nothing; instantiated by vector3_normalize_core.
module vnorm_root #(
	parameter int LANES = 1,
	parameter int KW    = 32,
	parameter int NW    = 66,
	parameter int DW    = 1,
	parameter int PW    = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [LANES-1:0][NW-1:0]    in_num,
	input  logic [DW-1:0]               in_div,
	input  logic [PW-1:0]               in_pay,
	output logic                        out_valid,
	output logic [LANES-1:0][KW-1:0]    out_root,
	output logic [PW-1:0]               out_pay
);

	localparam int MW = KW + DW;
	localparam int TW = (NW > 2 * KW + DW + 1) ? NW : 2 * KW + DW + 1;

	logic                       valid_s [KW+1];
	logic [LANES-1:0][KW-1:0]   root_s  [KW+1];
	logic [PW-1:0]              pay_s   [KW+1];
	logic [LANES-1:0][NW-1:0]   rem_s   [KW];
	logic [LANES-1:0][MW-1:0]   acc_s   [KW];
	logic [DW-1:0]              div_s   [KW];

	assign valid_s[0] = in_valid;
	assign root_s[0]  = '0;
	assign pay_s[0]   = in_pay;
	assign rem_s[0]   = in_num;
	assign acc_s[0]   = '0;
	assign div_s[0]   = in_div;

	generate
		for (genvar i = 0; i < KW; i++) begin : g_step
			localparam int J = KW - 1 - i;

			logic [LANES-1:0][TW-1:0] term;
			logic [LANES-1:0]         take;
			logic [LANES-1:0][KW-1:0] root_nx;

			// try setting bit J: (k + 2^J)^2 * d - k^2 * d = 2^(J+1) * k*d + 2^(2J) * d
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					term[l]    = (TW'(acc_s[i][l]) << (J + 1)) + (TW'(div_s[i]) << (2 * J));
					take[l]    = TW'(rem_s[i][l]) >= term[l];
					root_nx[l] = root_s[i][l] | (KW'(take[l]) << J);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[i+1] <= 1'b0;
				end else if (en) begin
					valid_s[i+1] <= valid_s[i];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					root_s[i+1] <= root_nx;
					pay_s[i+1]  <= pay_s[i];
				end
			end

			if (i < KW - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						for (int l = 0; l < LANES; l++) begin
							rem_s[i+1][l] <= take[l] ? rem_s[i][l] - term[l][NW-1:0]
							                         : rem_s[i][l];
							acc_s[i+1][l] <= take[l] ? acc_s[i][l] + (MW'(div_s[i]) << J)
							                         : acc_s[i][l];
						end
						div_s[i+1] <= div_s[i];
					end
				end
			end
		end
	endgenerate

	assign out_valid = valid_s[KW];
	assign out_root  = root_s[KW];
	assign out_pay   = pay_s[KW];

endmodule

FILE: design/vnorm_checker.sv
// Port-level checks for vector3_normalize_core, attached by the bind at the foot of the file.
// Depends on vnorm_pkg for default widths.
module vnorm_checker #(
	parameter int COMPONENT_WIDTH = vnorm_pkg::COMPONENT_WIDTH,
	parameter int FRACTION_BITS   = vnorm_pkg::FRACTION_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((3 * (FRACTION_BITS + 2) + COMPONENT_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
	input logic m_tuser
);

	localparam int CW = COMPONENT_WIDTH;
	localparam int UW = FRACTION_BITS + 2;
	localparam logic signed [UW-1:0] ONE = UW'(1) << FRACTION_BITS;

	logic [2:0] in_range;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_range[i] = ($signed(m_tdata[i*UW +: UW]) <= ONE)
			           && ($signed(m_tdata[i*UW +: UW]) >= -ONE);
		end
	end

	// a zero vector gives an all-zero result
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[3*UW+CW-1:0] == '0))
		else $error("zero_length result carries non-zero data");

	// any other vector has a non-zero length
	a_nonzero_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[3*UW +: CW] != '0))
		else $error("non-zero vector with zero magnitude");

	// unit components never leave [-1.0, 1.0]
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (in_range == 3'b111))
		else $error("unit component out of range");

	// with the output register free, the input side must take a transfer
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed under stall");

endmodule

bind vector3_normalize_core vnorm_checker #(
	.COMPONENT_WIDTH (COMPONENT_WIDTH),
	.FRACTION_BITS   (FRACTION_BITS)
) u_vnorm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
